// ----- design/sbl_pkg.sv -----
`timescale 1ns / 1ps

package sbl_pkg;

    // Fixed field widths.
    localparam int PIX_W     = 8;
    localparam int WREG_W    = 11;
    localparam int ROW_W     = 12;
    localparam int COL_OUT_W = 10;
    localparam int GRAD_W    = 11;
    localparam int SQ_W      = 20;
    localparam int SUM_W     = 21;
    localparam int VAL_W     = 16;
    localparam int ROOT_W    = 8;
    localparam int ROOT_STEPS = 8;

    // Smallest frame dimension that the block works with.
    localparam int MIN_DIM = 3;

    // Register reset values.
    localparam logic [WREG_W-1:0] WIDTH_RESET     = 11'd640;
    localparam logic [ROW_W-1:0]  HEIGHT_RESET    = 12'd480;
    localparam logic [ROW_W-1:0]  FIRST_ROW_RESET = 12'd0;

    // Saturated magnitude.
    localparam logic [PIX_W-1:0] SAT_MAX = 8'd255;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FIRST_ROW    = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_beat_t;

    // Result beat.
    typedef struct packed {
        logic [PIX_W-1:0]     edge_res;
        logic [COL_OUT_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
    } edge_beat_t;

    // Data handed from one square-root cell to the next.
    typedef struct packed {
        logic [VAL_W-1:0]     value;
        logic                 sat;
        logic [ROOT_W-1:0]    root;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
    } root_beat_t;

    // Front end sequencer states.
    typedef enum logic {
        FE_IDLE,
        FE_WRITE
    } fe_state_t;

endpackage

// ----- design/sbl_line_buf.sv -----
`timescale 1ns / 1ps

module sbl_line_buf
    import sbl_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [PIX_W-1:0] rd_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    // One write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/sbl_grad.sv -----
`timescale 1ns / 1ps

module sbl_grad
    import sbl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    in_valid,
    input  logic [8:0][PIX_W-1:0]   win,
    input  logic [COL_OUT_W-1:0]    col,
    input  logic [ROW_W-1:0]        row,
    output logic                    out_valid,
    output root_beat_t              out_beat
);

    logic [9:0]              left_sum;
    logic [9:0]              right_sum;
    logic [9:0]              top_sum;
    logic [9:0]              bottom_sum;
    logic signed [GRAD_W-1:0] gx_next;
    logic signed [GRAD_W-1:0] gy_next;

    logic                     a_valid_reg;
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic [COL_OUT_W-1:0]     a_col_reg;
    logic [ROW_W-1:0]         a_row_reg;

    logic signed [2*GRAD_W-1:0] prod_x;
    logic signed [2*GRAD_W-1:0] prod_y;
    logic                       b_valid_reg;
    logic [SQ_W-1:0]            sqx_reg;
    logic [SQ_W-1:0]            sqy_reg;
    logic [COL_OUT_W-1:0]       b_col_reg;
    logic [ROW_W-1:0]           b_row_reg;

    logic [SUM_W-1:0]           sum;
    logic                       c_valid_reg;
    root_beat_t                 c_beat_reg;

    // Weighted column and row sums of the window; the kernel is 1-2-1.
    always_comb
    begin
        left_sum   = {2'b00, win[0]} + {1'b0, win[3], 1'b0} + {2'b00, win[6]};
        right_sum  = {2'b00, win[2]} + {1'b0, win[5], 1'b0} + {2'b00, win[8]};
        top_sum    = {2'b00, win[0]} + {1'b0, win[1], 1'b0} + {2'b00, win[2]};
        bottom_sum = {2'b00, win[6]} + {1'b0, win[7], 1'b0} + {2'b00, win[8]};
        gx_next    = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        gy_next    = $signed({1'b0, bottom_sum}) - $signed({1'b0, top_sum});
    end

    // Stage A: gradients.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            gx_reg    <= gx_next;
            gy_reg    <= gy_next;
            a_col_reg <= col;
            a_row_reg <= row;
        end
    end

    // Stage B: squares. The square of a gradient, at most 1020 in magnitude, fits in 20 bits.
    assign prod_x = gx_reg * gx_reg;
    assign prod_y = gy_reg * gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sqx_reg   <= prod_x[SQ_W-1:0];
            sqy_reg   <= prod_y[SQ_W-1:0];
            b_col_reg <= a_col_reg;
            b_row_reg <= a_row_reg;
        end
    end

    // Stage C: sum of squares and the saturation flag.
    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_beat_reg.value <= sum[VAL_W-1:0];
            c_beat_reg.sat   <= (sum[SUM_W-1:VAL_W] != '0);
            c_beat_reg.root  <= '0;
            c_beat_reg.col   <= b_col_reg;
            c_beat_reg.row   <= b_row_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_beat  = c_beat_reg;

endmodule

// ----- design/sbl_root_cell.sv -----
`timescale 1ns / 1ps

module sbl_root_cell
    import sbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [2:0] bit_idx,
    input  logic       in_valid,
    input  root_beat_t in_beat,
    output logic       out_valid,
    output root_beat_t out_beat
);

    logic [ROOT_W-1:0]  trial;
    logic [2*ROOT_W-1:0] trial_sq;
    root_beat_t         beat_next;
    logic               valid_reg;
    root_beat_t         beat_reg;

    // Try to set one bit of the root; keep it if the square still fits.
    always_comb
    begin
        trial     = in_beat.root | (ROOT_W'(1) << bit_idx);
        trial_sq  = trial * trial;
        beat_next = in_beat;
        if (trial_sq <= in_beat.value)
        begin
            beat_next.root = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ----- design/sobel_edge_magnitude.sv -----
`timescale 1ns / 1ps

// Streaming 3x3 Sobel edge magnitude. Pixels arrive one per beat in raster
// order; the front end reads the two line stores at a pixel's column when
// it takes the pixel, then shifts the 3x3 window and writes the line stores
// back, and it takes no new pixel until that write-back is done. For every
// interior center at or below first_row the window feeds a pipeline of
// three arithmetic stages (gradients, squares, sum) and a row of eight
// square-root cells, one result bit per cell, followed by an output
// register. A stalled output holds the whole back end and then the front
// end; border pixels give no result beat. Registers at byte addresses 0, 4
// and 8 hold image_width, image_height and first_row; the user must write
// them only while the block is idle, and the block itself does not enforce
// this.

module sobel_edge_magnitude
    import sbl_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  pixel_beat_t pixel_data,
    output logic        edge_valid,
    input  logic        edge_stall,
    output edge_beat_t  edge_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (CNT_W > WREG_W) ? CNT_W : WREG_W;

    // Configuration registers.
    logic [WREG_W-1:0] image_width_reg;
    logic [ROW_W-1:0]  image_height_reg;
    logic [ROW_W-1:0]  first_row_reg;
    logic              cfg_write;

    // Front end.
    fe_state_t         fe_state_reg;
    fe_state_t         fe_state_next;
    logic              pixel_accept;
    logic              write_fire;
    logic              advance;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [PIX_W-1:0]  pixel_reg;
    logic [CMP_W-1:0]  width_ext;
    logic [CNT_W-1:0]  eff_width;
    logic [ROW_W-1:0]  eff_height;
    logic [ROW_W-1:0]  center_row;
    logic              want_result;

    // Line stores and window.
    logic [PIX_W-1:0]        upper_rd;
    logic [PIX_W-1:0]        middle_rd;
    logic [8:0][PIX_W-1:0]   win_reg;
    logic [8:0][PIX_W-1:0]   win_next;

    // Back end.
    logic                    cell_valid [ROOT_STEPS+1];
    root_beat_t              cell_beat  [ROOT_STEPS+1];
    logic                    edge_valid_reg;
    edge_beat_t              edge_data_reg;

    // Configuration port: writes and read back.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            first_row_reg    <= FIRST_ROW_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WREG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[ROW_W-1:0];
                REG_FIRST_ROW:    first_row_reg    <= pwdata[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            REG_FIRST_ROW:    prdata = 32'(first_row_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective frame size: both raised to at least MIN_DIM, and the width clamped to what the line stores can hold.
    always_comb
    begin
        width_ext = CMP_W'(image_width_reg);
        if (width_ext < CMP_W'(MIN_DIM))
        begin
            eff_width = CNT_W'(MIN_DIM);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            eff_width = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = CNT_W'(width_ext);
        end
        eff_height = (image_height_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM)
                                                         : image_height_reg;
    end

    // The back end moves whenever the output register can take a beat.
    assign advance = !edge_valid_reg || !edge_stall;

    // Sequencer: next state.
    always_comb
    begin
        fe_state_next = fe_state_reg;
        case (fe_state_reg)
            FE_IDLE:
            begin
                if (pixel_valid)
                begin
                    fe_state_next = FE_WRITE;
                end
            end
            FE_WRITE:
            begin
                if (advance)
                begin
                    fe_state_next = FE_IDLE;
                end
            end
            default: fe_state_next = FE_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        pixel_stall = 1'b1;
        write_fire  = 1'b0;
        case (fe_state_reg)
            FE_IDLE:  pixel_stall = 1'b0;
            FE_WRITE: write_fire  = advance;
            default:  pixel_stall = 1'b1;
        endcase
    end

    assign pixel_accept = pixel_valid && !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_state_reg <= FE_IDLE;
        end
        else
        begin
            fe_state_reg <= fe_state_next;
        end
    end

    // Position of the incoming pixel; a frame start or a stale count wraps.
    always_comb
    begin
        if (pixel_data.frame_start || (CNT_W'(col_reg) >= eff_width))
        begin
            cur_col_next = '0;
        end
        else
        begin
            cur_col_next = col_reg;
        end
        if (pixel_data.frame_start || (row_reg >= eff_height))
        begin
            cur_row_next = '0;
        end
        else
        begin
            cur_row_next = row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            pixel_reg   <= pixel_data.pixel;
        end
    end

    // Position of the following pixel.
    always_comb
    begin
        if (CNT_W'(cur_col_reg) + CNT_W'(1) >= eff_width)
        begin
            col_next = '0;
            if ({1'b0, cur_row_reg} + (ROW_W+1)'(1) >= {1'b0, eff_height})
            begin
                row_next = '0;
            end
            else
            begin
                row_next = cur_row_reg + ROW_W'(1);
            end
        end
        else
        begin
            col_next = cur_col_reg + COL_W'(1);
            row_next = cur_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (write_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Two line stores: the upper takes what the middle held at this column.
    sbl_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_upper (
        .clk     (clk),
        .wr_en   (write_fire),
        .wr_addr (cur_col_reg),
        .wr_data (middle_rd),
        .rd_en   (pixel_accept),
        .rd_addr (cur_col_next),
        .rd_data (upper_rd)
    );

    sbl_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_middle (
        .clk     (clk),
        .wr_en   (write_fire),
        .wr_addr (cur_col_reg),
        .wr_data (pixel_reg),
        .rd_en   (pixel_accept),
        .rd_addr (cur_col_next),
        .rd_data (middle_rd)
    );

    // Window shift: a new right-hand column enters from the line stores.
    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = upper_rd;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = middle_rd;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (write_fire)
        begin
            win_reg <= win_next;
        end
    end

    // Interior centers at or below first_row give a result.
    assign center_row  = cur_row_reg - ROW_W'(1);
    assign want_result = (cur_col_reg >= COL_W'(2)) && (cur_row_reg >= ROW_W'(2))
                         && (center_row >= first_row_reg);

    sbl_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (write_fire && want_result),
        .win       (win_next),
        .col       (COL_OUT_W'(cur_col_reg - COL_W'(1))),
        .row       (center_row),
        .out_valid (cell_valid[0]),
        .out_beat  (cell_beat[0])
    );

    // Square-root cells, most significant result bit first.
    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_root
        sbl_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .bit_idx   (3'(ROOT_STEPS - 1 - i)),
            .in_valid  (cell_valid[i]),
            .in_beat   (cell_beat[i]),
            .out_valid (cell_valid[i+1]),
            .out_beat  (cell_beat[i+1])
        );
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            edge_valid_reg <= cell_valid[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            edge_data_reg.edge_res   <= cell_beat[ROOT_STEPS].sat ? SAT_MAX
                                                              : cell_beat[ROOT_STEPS].root;
            edge_data_reg.center_col <= cell_beat[ROOT_STEPS].col;
            edge_data_reg.center_row <= cell_beat[ROOT_STEPS].row;
        end
    end

    assign edge_valid = edge_valid_reg;
    assign edge_data  = edge_data_reg;

    // An accepted pixel always moves on to the write-back cycle.
    a_accept_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_accept |=> (fe_state_reg == FE_WRITE))
        else $error("accepted pixel did not reach write-back");

    // While the back end is held, the position counters do not move.
    a_hold_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (fe_state_reg == FE_WRITE && !advance) |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("position counters moved while held");

    // A result never belongs to the top border row.
    a_center_row: assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid_reg |-> (edge_data_reg.center_row != '0))
        else $error("result for a border row");

endmodule

// ----- tb/tb_sobel_edge_magnitude.sv -----
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude;
    import sbl_pkg::*;

    localparam int MAX_W = 1024;
    localparam int DRAIN_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS = 250;
    localparam int PHASE_CAP = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pixel_valid = 1'b0;
    logic        pixel_stall;
    pixel_beat_t pixel_data = '0;
    logic        edge_valid;
    logic        edge_stall = 1'b0;
    edge_beat_t  edge_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus and expectation stores.
    pixel_beat_t pending_pixels[$];
    edge_beat_t  expected_edges[$];
    int          error_count = 0;
    bit          jitter_on = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;

    // Shadow of the block: registers, line stores, window and position.
    logic [WREG_W-1:0] cfg_width = WIDTH_RESET;
    logic [ROW_W-1:0]  cfg_height = HEIGHT_RESET;
    logic [ROW_W-1:0]  cfg_first_row = FIRST_ROW_RESET;
    logic [PIX_W-1:0]  upper_line[MAX_W];
    logic [PIX_W-1:0]  middle_line[MAX_W];
    logic [PIX_W-1:0]  win[9];
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;

    sobel_edge_magnitude #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel_data(pixel_data),
        .edge_valid(edge_valid),
        .edge_stall(edge_stall),
        .edge_data(edge_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    function automatic int unsigned eff_width(int unsigned v);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > MAX_W)
            return MAX_W;
        return v;
    endfunction

    function automatic int unsigned eff_height(int unsigned v);
        return (v < MIN_DIM) ? MIN_DIM : v;
    endfunction

    // Largest integer whose square does not exceed v.
    function automatic int unsigned floor_root(int unsigned v);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    // Advance the shadow by one accepted pixel and queue the edge beat it yields.
    function automatic void predict_edge(pixel_beat_t beat);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned sum;
        int          p[9];
        int          gx;
        int          gy;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        edge_beat_t res;
        w = eff_width(cfg_width);
        h = eff_height(cfg_height);
        if (beat.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        up = upper_line[c];
        mid = middle_line[c];
        win[0] = win[1]; win[1] = win[2]; win[2] = up;
        win[3] = win[4]; win[4] = win[5]; win[5] = mid;
        win[6] = win[7]; win[7] = win[8]; win[8] = beat.pixel;
        upper_line[c] = mid;
        middle_line[c] = beat.pixel;
        if (c >= 2 && r >= 2 && (r - 1) >= cfg_first_row)
        begin
            for (int i = 0; i < 9; i++)
                p[i] = win[i];
            gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
            gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
            sum = gx * gx + gy * gy;
            res.edge_res = (sum >= 65536) ? SAT_MAX : PIX_W'(floor_root(sum));
            res.center_col = COL_OUT_W'(c - 1);
            res.center_row = ROW_W'(r - 1);
            expected_edges.push_back(res);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endfunction

    // Pixel driver: takes beats from the pending queue, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
                predict_edge(pixel_data);
            if (!pixel_valid || !pixel_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    pixel_valid <= 1'b0;
                end
                else if (jitter_on && $urandom_range(0, 9) == 0)
                begin
                    send_gap <= $urandom_range(0, 5);
                    pixel_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    pixel_data <= pending_pixels.pop_front();
                    pixel_valid <= 1'b1;
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            edge_stall <= 1'b1;
        end
        else if (jitter_on && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            edge_stall <= 1'b1;
        end
        else
            edge_stall <= 1'b0;
    end

    // Result monitor: every accepted beat must match the oldest expectation.
    always @(posedge clk)
    begin : check_edges
        edge_beat_t want;
        if (rst_n && edge_valid && !edge_stall)
        begin
            if (expected_edges.size() == 0)
            begin
                $display("%0t: unexpected edge beat, expected none, actual %p",
                         $time, edge_data);
                error_count++;
            end
            else
            begin
                want = expected_edges.pop_front();
                if (edge_data.edge_res !== want.edge_res)
                begin
                    $display("%0t: edge_res mismatch, expected %0d, actual %0d",
                             $time, want.edge_res, edge_data.edge_res);
                    error_count++;
                end
                if (edge_data.center_col !== want.center_col)
                begin
                    $display("%0t: center_col mismatch, expected %0d, actual %0d",
                             $time, want.center_col, edge_data.center_col);
                    error_count++;
                end
                if (edge_data.center_row !== want.center_row)
                begin
                    $display("%0t: center_row mismatch, expected %0d, actual %0d",
                             $time, want.center_row, edge_data.center_row);
                    error_count++;
                end
            end
        end
    end

    // Setup and access cycle; the register takes the value at the access edge.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_IMAGE_WIDTH:  cfg_width = value[WREG_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = value[ROW_W-1:0];
            REG_FIRST_ROW:    cfg_first_row = value[ROW_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until all pixels are taken and all edge beats have come back.
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || pixel_valid);
        while (expected_edges.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_edges.size() != 0)
        begin
            $display("%0t: %0d edge beats missing, oldest expected %p, actual none",
                     $time, expected_edges.size(), expected_edges[0]);
            error_count++;
            expected_edges.delete();
        end
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(int mode, logic [PIX_W-1:0] base);
        case (mode)
            1:       return PIX_W'(base + $urandom_range(0, 20));
            2:       return $urandom_range(0, 1) ? SAT_MAX : '0;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_pixel(logic [PIX_W-1:0] value, logic start);
        pixel_beat_t beat;
        beat.pixel = value;
        beat.frame_start = start;
        pending_pixels.push_back(beat);
    endtask

    // One phase: program all registers while idle, stream pixels, drain.
    task automatic run_phase(int unsigned width_val, int unsigned height_val,
                             int unsigned first_val, int unsigned count,
                             bit with_start, bit noise, int mode);
        logic [PIX_W-1:0] base;
        logic             start;
        write_reg(REG_IMAGE_WIDTH, width_val);
        write_reg(REG_IMAGE_HEIGHT, height_val);
        write_reg(REG_FIRST_ROW, first_val);
        base = $urandom_range(0, 235);
        @(negedge clk);
        for (int unsigned i = 0; i < count; i++)
        begin
            start = (i == 0 && with_start) || (noise && $urandom_range(0, 149) == 0);
            queue_pixel(make_pixel(mode, base), start);
        end
        wait_idle();
    endtask

    // Picks a random geometry and runs one phase with it.
    task automatic random_phase(output int unsigned count);
        int unsigned width_val;
        int unsigned height_val;
        int unsigned first_val;
        int unsigned area;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        width_val = (pick < 7) ? $urandom_range(3, 16) :
                    (pick < 8) ? $urandom_range(0, 2) : $urandom_range(17, 40);
        pick = $urandom_range(0, 19);
        height_val = (pick < 14) ? $urandom_range(3, 8) :
                     (pick < 17) ? $urandom_range(0, 2) : $urandom_range(9, 30);
        pick = $urandom_range(0, 9);
        first_val = (pick < 6) ? 0 :
                    (pick < 8) ? $urandom_range(0, eff_height(height_val)) :
                    (pick < 9) ? 1 : $urandom_range(eff_height(height_val), 4095);
        area = eff_width(width_val) * eff_height(height_val);
        count = area * ((area > 150) ? 1 : $urandom_range(1, 3))
                + $urandom_range(0, 2 * eff_width(width_val));
        if (count > PHASE_CAP)
            count = PHASE_CAP;
        run_phase(width_val, height_val, first_val, count, 1'b1,
                  $urandom_range(0, 2) == 0, $urandom_range(0, 2));
    endtask

    initial
    begin : stimulus
        int unsigned random_items;
        int unsigned count;
        random_items = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: smallest frames, saturated and exact magnitudes,
        // wrap without frame_start, a broken frame restarted by frame_start.
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_FIRST_ROW, 0);
        @(negedge clk);
        queue_pixel(8'd0, 1'b1); queue_pixel(8'd7, 1'b0);   queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd0, 1'b0); queue_pixel(8'd100, 1'b0); queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd0, 1'b0); queue_pixel(8'd200, 1'b0); queue_pixel(8'd255, 1'b0);
        for (int i = 0; i < 8; i++)
            queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd1, 1'b0);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd255, 1'b0);
        for (int i = 1; i <= 9; i++)
            queue_pixel(PIX_W'(10 * i), i == 1);
        wait_idle();

        // A width above the maximum: the first line does not wrap early.
        jitter_on = 1'b1;
        run_phase(2047, 3, 0, 40, 1'b1, 1'b0, 1);

        // Tallest frame; only rows from first_row on give results.
        run_phase(3, 4095, 20, 3 * 30, 1'b1, 1'b0, 0);

        // first_row beyond any frame: no results at all.
        run_phase(4, 5, 4095, 40, 1'b1, 1'b1, 0);

        // Width and height shrink in mid-image, with no new frame_start.
        run_phase(12, 6, 0, 12 * 6 + 5, 1'b1, 1'b0, 0);
        run_phase(5, 4, 1, 60, 1'b0, 1'b0, 1);

        // Random geometries and content, some phases with no idling.
        while (random_items < RANDOM_ITEMS)
        begin
            jitter_on = ($urandom_range(0, 3) != 0);
            random_phase(count);
            random_items += count;
        end

        // Closing phases at full rate on both sides.
        jitter_on = 1'b0;
        repeat (2)
            random_phase(count);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
